[rtl/ats_pkg.sv]
// ----------------------------------------------------------------------------
// ats_pkg
// Shared types and constants of the audio take statistics block.
// ----------------------------------------------------------------------------
package ats_pkg;

  localparam int MAX_SAMPLES = 65536;
  localparam int SMP_W       = 16;
  localparam int CNT_W       = 17;
  localparam int CROSS_W     = 16;
  localparam int SUM_W       = 47;
  localparam int SQ_W        = 2 * SMP_W;
  localparam int RMS_W       = 16;
  localparam int LIM_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int QUO_W       = 2 * RMS_W;
  localparam int UNIT_W      = CNT_W + 3;
  localparam int REM_W       = UNIT_W - 1;
  localparam int STEP_W      = 6;
  localparam int DIV_STEPS   = SUM_W;
  localparam int ROOT_STEPS  = RMS_W;

  localparam logic [CFG_IDX_W-1:0] REG_FLAT_SPAN   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_RMS = CFG_IDX_W'(1);

  localparam logic       OP_ADD    = 1'b0;
  localparam logic       OP_FINISH = 1'b1;

  localparam logic [1:0] VERDICT_NO_DATA = 2'd0;
  localparam logic [1:0] VERDICT_FLAT    = 2'd1;
  localparam logic [1:0] VERDICT_SILENT  = 2'd2;
  localparam logic [1:0] VERDICT_ENERGY  = 2'd3;

  localparam logic [LIM_W-1:0] FLAT_SPAN_RESET   = LIM_W'(8);
  localparam logic [LIM_W-1:0] SILENCE_RMS_RESET = LIM_W'(30);

  localparam logic signed [SMP_W-1:0] MIN_RESET = 16'sh7fff;
  localparam logic signed [SMP_W-1:0] MAX_RESET = 16'sh8000;

  typedef struct packed {
    logic                    operation;
    logic signed [SMP_W-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] min_value;
    logic signed [SMP_W-1:0] max_value;
    logic [RMS_W-1:0]        rms_level;
    logic [CROSS_W-1:0]      zero_crossings;
    logic [CNT_W-1:0]        sample_count;
    logic [1:0]              verdict;
    logic                    overflowed;
  } out_word_t;

  typedef struct packed {
    logic add;
    logic sq_add;
    logic clear;
  } acc_ctrl_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] min_value;
    logic signed [SMP_W-1:0] max_value;
    logic [SUM_W-1:0]        square_sum;
    logic [CNT_W-1:0]        count;
    logic [CROSS_W-1:0]      crossings;
    logic                    overflow;
  } acc_stats_t;

endpackage

[rtl/ats_accum.sv]
// ----------------------------------------------------------------------------
// ats_accum
// Running min, max, sum of squares, count and zero crossings of one take.
// ----------------------------------------------------------------------------
module ats_accum (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ats_pkg::acc_ctrl_t            ctrl,
  input  logic signed [ats_pkg::SMP_W-1:0] sample,
  output ats_pkg::acc_stats_t           stats
);
  import ats_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

  logic signed [SMP_W-1:0] min_r, min_nxt;
  logic signed [SMP_W-1:0] max_r, max_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CROSS_W-1:0]      cross_r, cross_nxt;
  logic                    prev_neg_r, prev_neg_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [SQ_W-1:0]         sq_r, sq_nxt;
  logic                    neg;
  logic [SMP_W-1:0]        mag;
  logic                    full;

  always_comb begin
    neg          = sample[SMP_W-1];
    mag          = neg ? SMP_W'(-sample) : SMP_W'(sample);
    full         = (cnt_r >= MAX_CNT);
    min_nxt      = min_r;
    max_nxt      = max_r;
    sum_nxt      = sum_r;
    cnt_nxt      = cnt_r;
    cross_nxt    = cross_r;
    prev_neg_nxt = prev_neg_r;
    ovf_nxt      = ovf_r;
    sq_nxt       = sq_r;
    if (ctrl.clear) begin
      min_nxt      = MIN_RESET;
      max_nxt      = MAX_RESET;
      sum_nxt      = '0;
      cnt_nxt      = '0;
      cross_nxt    = '0;
      prev_neg_nxt = 1'b0;
      ovf_nxt      = 1'b0;
    end else if (ctrl.add) begin
      if (full) begin
        ovf_nxt = 1'b1;
        sq_nxt  = '0;
      end else begin
        if (sample < min_r) begin
          min_nxt = sample;
        end
        if (sample > max_r) begin
          max_nxt = sample;
        end
        if ((cnt_r != '0) && (neg != prev_neg_r) && (cross_r != '1)) begin
          cross_nxt = cross_r + CROSS_W'(1);
        end
        prev_neg_nxt = neg;
        cnt_nxt      = cnt_r + CNT_W'(1);
        sq_nxt       = SQ_W'(mag) * SQ_W'(mag);
      end
    end else if (ctrl.sq_add) begin
      sum_nxt = sum_r + SUM_W'(sq_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r      <= MIN_RESET;
      max_r      <= MAX_RESET;
      sum_r      <= '0;
      cnt_r      <= '0;
      cross_r    <= '0;
      prev_neg_r <= 1'b0;
      ovf_r      <= 1'b0;
    end else begin
      min_r      <= min_nxt;
      max_r      <= max_nxt;
      sum_r      <= sum_nxt;
      cnt_r      <= cnt_nxt;
      cross_r    <= cross_nxt;
      prev_neg_r <= prev_neg_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sq_r <= sq_nxt;
  end

  assign stats.min_value  = min_r;
  assign stats.max_value  = max_r;
  assign stats.square_sum = sum_r;
  assign stats.count      = cnt_r;
  assign stats.crossings  = cross_r;
  assign stats.overflow   = ovf_r;

endmodule

[rtl/ats_divroot.sv]
// ----------------------------------------------------------------------------
// ats_divroot
// Iterative restoring divide then square root over one shared subtractor.
// ----------------------------------------------------------------------------
module ats_divroot (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ats_pkg::SUM_W-1:0]   dividend,
  input  logic [ats_pkg::CNT_W-1:0]   divisor,
  output logic                        done,
  output logic [ats_pkg::RMS_W-1:0]   root
);
  import ats_pkg::*;

  typedef enum logic [2:0] {
    DR_IDLE = 3'b001,
    DR_DIV  = 3'b010,
    DR_ROOT = 3'b100
  } dr_state_t;

  dr_state_t          state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [SUM_W-1:0]   num_r, num_nxt;
  logic [CNT_W-1:0]   den_r, den_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [RMS_W-1:0]   root_r, root_nxt;
  logic               done_r, done_nxt;
  logic [UNIT_W-1:0]  op_a, op_b;
  logic [UNIT_W:0]    diff;
  logic               fits;

  // shared subtract and compare
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state_r == DR_ROOT) begin
      op_a = {rem_r[REM_W-2:0], num_r[QUO_W-1 -: 2]};
      op_b = UNIT_W'({root_r, 2'b01});
    end else begin
      op_a = UNIT_W'({rem_r, num_r[SUM_W-1]});
      op_b = UNIT_W'(den_r);
    end
    diff = {1'b0, op_a} - {1'b0, op_b};
    fits = ~diff[UNIT_W];
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      DR_IDLE: begin
        if (start) begin
          num_nxt   = dividend;
          den_nxt   = divisor;
          rem_nxt   = '0;
          step_nxt  = STEP_W'(DIV_STEPS - 1);
          state_nxt = DR_DIV;
        end
      end
      DR_DIV: begin
        rem_nxt = fits ? REM_W'(diff) : REM_W'(op_a);
        num_nxt = {num_r[SUM_W-2:0], fits};
        if (step_r == '0) begin
          rem_nxt   = '0;
          root_nxt  = '0;
          step_nxt  = STEP_W'(ROOT_STEPS - 1);
          state_nxt = DR_ROOT;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      DR_ROOT: begin
        rem_nxt  = fits ? REM_W'(diff) : REM_W'(op_a);
        root_nxt = {root_r[RMS_W-2:0], fits};
        num_nxt  = {num_r[SUM_W-3:0], 2'b00};
        if (step_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = DR_IDLE;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      default: begin
        state_nxt = DR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DR_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

[rtl/audio_take_statistics.sv]
// ----------------------------------------------------------------------------
// audio_take_statistics
// Running statistics over one capture of signed 16-bit audio samples.
//
// in_word carries an operation and a sample. An add word updates min, max,
// sum of squares, sample count and zero crossings; its square is registered
// and then added into the 47-bit sum in ST_ACC. A finish word produces one
// out_word: the sum is divided by the count and the root taken on one shared
// subtractor, one bit per cycle (skipped for an empty take). out_valid rises
// when the report is loaded, and the next word can be taken in the same
// cycle. The take is cleared as the report is loaded. Add words give no
// out_word. Samples past 65536 are dropped and flagged. in_ready is low while
// a word is in progress. out_word sits in an output register; new words are
// taken while it waits, but the next finish holds until the receiver has
// taken the previous report.
// cfg_index 0 writes the flat span limit, 1 the silence rms limit; other
// indexes are ignored. cfg_ready is always high; write only while idle.
// Reset (rst_n low, synchronous) clears the take and loads limits 8 and 30.
// ----------------------------------------------------------------------------
module audio_take_statistics (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ats_pkg::in_word_t                 in_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ats_pkg::out_word_t                out_word,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ats_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ats_pkg::LIM_W-1:0]         cfg_data
);
  import ats_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ACC  = 4'b0010,
    ST_CALC = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [LIM_W-1:0]        flat_lim_r, silence_lim_r;
  out_word_t               out_word_r, out_word_nxt;
  logic                    out_valid_r, out_valid_nxt;
  acc_ctrl_t               acc_ctrl;
  acc_stats_t              stats;
  logic                    in_take;
  logic                    dr_start;
  logic                    dr_done;
  logic [RMS_W-1:0]        dr_root;
  logic [RMS_W-1:0]        rms;
  logic signed [SMP_W+1:0] span;
  logic [1:0]              verdict;
  logic                    out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_take   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  ats_accum u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (acc_ctrl),
    .sample (in_word.sample),
    .stats  (stats)
  );

  ats_divroot u_divroot (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dr_start),
    .dividend (stats.square_sum),
    .divisor  (stats.count),
    .done     (dr_done),
    .root     (dr_root)
  );

  // report fields
  always_comb begin
    rms  = (stats.count == '0) ? '0 : dr_root;
    span = (SMP_W+2)'(stats.max_value) - (SMP_W+2)'(stats.min_value);
    if (stats.count == '0) begin
      verdict = VERDICT_NO_DATA;
    end else if (span < $signed({2'b00, flat_lim_r})) begin
      verdict = VERDICT_FLAT;
    end else if (rms < silence_lim_r) begin
      verdict = VERDICT_SILENT;
    end else begin
      verdict = VERDICT_ENERGY;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    out_word_nxt    = out_word_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    acc_ctrl        = '0;
    dr_start        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          if (in_word.operation == OP_ADD) begin
            acc_ctrl.add = 1'b1;
            state_nxt    = ST_ACC;
          end else if (stats.count == '0) begin
            state_nxt = ST_DONE;
          end else begin
            dr_start  = 1'b1;
            state_nxt = ST_CALC;
          end
        end
      end
      ST_ACC: begin
        acc_ctrl.sq_add = 1'b1;
        state_nxt       = ST_IDLE;
      end
      ST_CALC: begin
        if (dr_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_word_nxt.min_value      = stats.min_value;
          out_word_nxt.max_value      = stats.max_value;
          out_word_nxt.rms_level      = rms;
          out_word_nxt.zero_crossings = stats.crossings;
          out_word_nxt.sample_count   = stats.count;
          out_word_nxt.verdict        = verdict;
          out_word_nxt.overflowed     = stats.overflow;
          out_valid_nxt               = 1'b1;
          acc_ctrl.clear              = 1'b1;
          state_nxt                   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      flat_lim_r    <= FLAT_SPAN_RESET;
      silence_lim_r <= SILENCE_RMS_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_FLAT_SPAN:   flat_lim_r    <= cfg_data;
          REG_SILENCE_RMS: silence_lim_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_take_statistics testbench
// Sends audio takes of add words closed by finish words, predicts each take
// report with an independent model, and checks every report field in order.
// Covers empty, flat, quiet and loud takes, the limit registers at several
// settings including both extremes, and random backpressure on both
// channels.
// ----------------------------------------------------------------------------
module testbench;
  import ats_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 80;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  typedef enum int {STYLE_WIDE, STYLE_QUIET, STYLE_STEADY, STYLE_EDGES, STYLE_NOISE}
    take_style_t;

  class take_scoreboard;
    logic [LIM_W-1:0]        flat_span_lim;
    logic [LIM_W-1:0]        silence_lim;
    logic signed [SMP_W-1:0] lo;
    logic signed [SMP_W-1:0] hi;
    logic [SUM_W-1:0]        sq_sum;
    logic [CNT_W-1:0]        n;
    logic [CROSS_W-1:0]      crossings;
    logic                    last_neg;
    logic                    dropped;
    out_word_t               expected_reports[$];
    int                      mismatches;

    function new();
      flat_span_lim = FLAT_SPAN_RESET;
      silence_lim   = SILENCE_RMS_RESET;
      mismatches    = 0;
      clear_take();
    endfunction

    function void clear_take();
      lo        = MIN_RESET;
      hi        = MAX_RESET;
      sq_sum    = '0;
      n         = '0;
      crossings = '0;
      last_neg  = 1'b0;
      dropped   = 1'b0;
    endfunction

    function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [LIM_W-1:0] val);
      case (idx)
        REG_FLAT_SPAN:   flat_span_lim = val;
        REG_SILENCE_RMS: silence_lim = val;
        default: ;
      endcase
    endfunction

    function void note_word(in_word_t w);
      int                v;
      longint unsigned   mean;
      longint unsigned   root;
      longint unsigned   trial;
      out_word_t         rep;
      v = int'(w.sample);
      if (w.operation == OP_ADD) begin
        if (int'(n) >= MAX_SAMPLES) begin
          dropped = 1'b1;
        end else begin
          if (w.sample < lo) lo = w.sample;
          if (w.sample > hi) hi = w.sample;
          sq_sum += SUM_W'(longint'(v) * longint'(v));
          if (n != 0 && (v < 0) != last_neg && crossings != '1) crossings++;
          last_neg = (v < 0);
          n++;
        end
      end else begin
        rep.min_value      = lo;
        rep.max_value      = hi;
        rep.zero_crossings = crossings;
        rep.sample_count   = n;
        rep.overflowed     = dropped;
        rep.rms_level      = '0;
        rep.verdict        = VERDICT_NO_DATA;
        if (n != 0) begin
          mean = sq_sum;
          mean = mean / n;
          root = 0;
          // square root built one bit at a time from the top
          for (int b = RMS_W; b >= 0; b--) begin
            trial = root + (64'd1 << b);
            if (trial * trial <= mean) root = trial;
          end
          rep.rms_level = RMS_W'(root);
          if (int'(hi) - int'(lo) < int'(flat_span_lim)) rep.verdict = VERDICT_FLAT;
          else if (root < silence_lim) rep.verdict = VERDICT_SILENT;
          else rep.verdict = VERDICT_ENERGY;
        end
        expected_reports.push_back(rep);
        clear_take();
      end
    endfunction

    function void compare_field(string name, logic signed [31:0] want_v,
                                logic signed [31:0] got_v);
      if (want_v !== got_v) begin
        mismatches++;
        if (mismatches <= 10)
          $display("report %s mismatch: expected %0d, got %0d", name, want_v, got_v);
      end
    endfunction

    function void check_report(out_word_t got);
      out_word_t want;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("report with no take pending: min %0d max %0d count %0d",
                   got.min_value, got.max_value, got.sample_count);
        return;
      end
      want = expected_reports.pop_front();
      compare_field("min_value", want.min_value, got.min_value);
      compare_field("max_value", want.max_value, got.max_value);
      compare_field("rms_level", want.rms_level, got.rms_level);
      compare_field("zero_crossings", want.zero_crossings, got.zero_crossings);
      compare_field("sample_count", want.sample_count, got.sample_count);
      compare_field("verdict", want.verdict, got.verdict);
      compare_field("overflowed", want.overflowed, got.overflowed);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_word_t             in_word   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_word;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LIM_W-1:0]     cfg_data  = '0;

  take_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent    = 0;
  int cycle_count   = 0;

  audio_take_statistics u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("audio_take_statistics regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_report(out_word);
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic send_word(logic op, logic signed [SMP_W-1:0] smp);
    in_word_t w;
    w.operation = op;
    w.sample    = smp;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(w);
    items_sent++;
  endtask

  task automatic wait_reports();
    in_valid <= 1'b0;
    while (sb.expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limits(logic [LIM_W-1:0] flat, logic [LIM_W-1:0] silence);
    logic [CFG_IDX_W-1:0] idx[4];
    logic [LIM_W-1:0]     val[4];
    idx = '{REG_SPARE_A, REG_SPARE_B, REG_FLAT_SPAN, REG_SILENCE_RMS};
    val = '{LIM_W'($urandom), LIM_W'($urandom), flat, silence};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.set_limit(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [SMP_W-1:0] pick_sample(take_style_t style,
                                                         logic signed [SMP_W-1:0] base);
    case (style)
      STYLE_QUIET:  return SMP_W'(int'($urandom_range(0, 80)) - 40);
      STYLE_STEADY: return base + SMP_W'(int'($urandom_range(0, 6)) - 3);
      STYLE_EDGES: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh8000;
          1:       return 16'sh7fff;
          2:       return '0;
          default: return '1;
        endcase
      end
      default:      return SMP_W'($urandom);
    endcase
  endfunction

  task automatic send_take(take_style_t style, int len);
    logic signed [SMP_W-1:0] base;
    base = SMP_W'($urandom);
    for (int i = 0; i < len; i++) begin
      if (style == STYLE_NOISE)
        send_word(($urandom_range(0, 4) == 0) ? OP_FINISH : OP_ADD, SMP_W'($urandom));
      else
        send_word(OP_ADD, pick_sample(style, base));
    end
    send_word(OP_FINISH, SMP_W'($urandom));
  endtask

  initial begin
    int          target;
    int          len;
    take_style_t style;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 15;
    recv_idle_pct = 49;

    // empty take right after reset
    send_word(OP_FINISH, '0);
    // single zero sample
    send_word(OP_ADD, '0);
    send_word(OP_FINISH, '0);
    // full-scale negative, largest rms
    send_word(OP_ADD, 16'sh8000);
    send_word(OP_ADD, 16'sh8000);
    send_word(OP_FINISH, '1);
    // extremes with crossings through zero
    send_word(OP_ADD, 16'sh7fff);
    send_word(OP_ADD, 16'sh8000);
    send_word(OP_ADD, '0);
    send_word(OP_ADD, '1);
    send_word(OP_ADD, 16'sd1);
    send_word(OP_FINISH, '0);
    // wide span but low level
    send_word(OP_ADD, 16'sd10);
    send_word(OP_ADD, -16'sd10);
    send_word(OP_ADD, 16'sd20);
    send_word(OP_FINISH, '0);
    // back-to-back finish
    send_word(OP_FINISH, '0);
    wait_reports();

    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 49;
        end
        1: begin
          send_idle_pct = 49;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (p)
        0:       write_limits('0, '0);
        1:       write_limits('1, LIM_W'(32768));
        4:       write_limits(FLAT_SPAN_RESET, SILENCE_RMS_RESET);
        default: write_limits(LIM_W'($urandom_range(0, 300)),
                              LIM_W'($urandom_range(0, 3000)));
      endcase
      target = items_sent + 165;
      while (items_sent < target) begin
        style = ($urandom_range(0, 9) == 0) ? STYLE_NOISE
                                            : take_style_t'($urandom_range(0, 3));
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 40);
        send_take(style, len);
      end
      wait_reports();
    end

    if (sb.mismatches == 0 && sb.expected_reports.size() == 0) begin
      $display("audio_take_statistics regression: pass");
    end else begin
      $display("audio_take_statistics regression: fail");
    end
    $finish;
  end

endmodule
